FILE: rtl/preemptive_srtf_scheduler_macros.svh
// Assertion macros for the preemptive SRTF scheduler.
`ifndef PREEMPTIVE_SRTF_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_SRTF_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRTF_ASSERT(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define SRTF_ASSERT(lbl, expr, msg)
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/srtf_pkg.sv
// Types and constants shared by the SRTF scheduler.
package srtf_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 8;
   localparam int WORK_WIDTH  = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_W      = 32;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef enum logic [2:0] {
      STATUS_ACCEPT = 3'd0,
      STATUS_FULL   = 3'd1,
      STATUS_ZERO   = 3'd2,
      STATUS_RAN    = 3'd3,
      STATUS_DONE   = 3'd4,
      STATUS_IDLE   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_TICK
   } state_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]   id;
      logic [WORK_WIDTH-1:0] work;
   } entry_type;

endpackage

FILE: rtl/preemptive_srtf_scheduler.sv
// Preemptive shortest-remaining-time-first scheduler, top level.
//
// Usage: drive req_cmd, req_job_id and req_work_units and raise start; the
// request is taken at a clock edge where start is high and busy is low.
// An arrive request (req_cmd 0) appends a job to a ready list of
// QUEUE_DEPTH entries unless the list is full or the job has no work; a
// tick request (req_cmd 1) runs one job, if there is one, for one time
// unit. Every request yields exactly one response, shown for a single
// cycle with rsp_strobe high; the receiver cannot stall it.
// Sequencing: an arrive request answers in the next cycle and busy stays
// low, so arrivals go back to back. A tick runs a sequencer over the
// ready-list memory (one read port, one write port): a minimum scan with
// one comparator over the ready entries, then a compaction pass over the
// entries behind the chosen job, then the tick state. A tick with no scan
// goes straight to the tick state; a preemption scan runs after the
// response, while busy is still high. The longest tick picks up the first
// entry of a full list and then scans the rest for preemption.
// Reset: synchronous, active high; empties the ready list, clears the
// running job and the tick count. List memory contents are not cleared.
module preemptive_srtf_scheduler
   import srtf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  logic [ID_WIDTH-1:0]   req_job_id,
   input  logic [WORK_WIDTH-1:0] req_work_units,
   output logic                  rsp_strobe,
   output status_type            rsp_status,
   output logic [ID_WIDTH-1:0]   rsp_run_id,
   output logic [WORK_WIDTH-1:0] rsp_left_after,
   output logic [TIME_W-1:0]     rsp_finish_time
);

`include "preemptive_srtf_scheduler_macros.svh"

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  run_valid_ff, run_valid_in;
   logic [ID_WIDTH-1:0]   run_id_ff, run_id_in;
   logic [WORK_WIDTH-1:0] run_work_ff, run_work_in;
   logic [TIME_W-1:0]     tick_ff, tick_in;
   logic                  preempt_ff, preempt_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  vld_ff, vld_in;
   logic [CNT_W-1:0]      cmp_idx_ff, cmp_idx_in;
   entry_type             best_ff, best_in;
   logic [IDX_W-1:0]      best_pos_ff, best_pos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ID_WIDTH-1:0]   rsp_run_id_ff, rsp_run_id_in;
   logic [WORK_WIDTH-1:0] rsp_left_ff, rsp_left_in;
   logic [TIME_W-1:0]     rsp_fin_ff, rsp_fin_in;

   entry_type             ready_ff [QUEUE_DEPTH];
   entry_type             rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   logic                  issue;
   logic [CNT_W-1:0]      wr_pos;
   logic [CNT_W-1:0]      count_dec;
   logic [WORK_WIDTH-1:0] left;
   logic [TIME_W-1:0]     tick_next;

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_run_id      = rsp_run_id_ff;
   assign rsp_left_after  = rsp_left_ff;
   assign rsp_finish_time = rsp_fin_ff;

   assign issue     = (scan_ff < count_ff);
   assign wr_pos    = cmp_idx_ff - CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign left      = run_work_ff - WORK_WIDTH'(1);
   assign tick_next = tick_ff + TIME_W'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ready_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ready_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         run_valid_ff <= 1'b0;
         run_id_ff    <= '0;
         run_work_ff  <= '0;
         tick_ff      <= '0;
         preempt_ff   <= 1'b0;
         scan_ff      <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_valid_ff <= run_valid_in;
         run_id_ff    <= run_id_in;
         run_work_ff  <= run_work_in;
         tick_ff      <= tick_in;
         preempt_ff   <= preempt_in;
         scan_ff      <= scan_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff    <= cmp_idx_in;
      best_ff       <= best_in;
      best_pos_ff   <= best_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_run_id_ff <= rsp_run_id_in;
      rsp_left_ff   <= rsp_left_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      run_valid_in  = run_valid_ff;
      run_id_in     = run_id_ff;
      run_work_in   = run_work_ff;
      tick_in       = tick_ff;
      preempt_in    = preempt_ff;
      scan_in       = scan_ff;
      vld_in        = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_in       = best_ff;
      best_pos_in   = best_pos_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_run_id_in = rsp_run_id_ff;
      rsp_left_in   = rsp_left_ff;
      rsp_fin_in    = rsp_fin_ff;
      rd_addr       = scan_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = '{id: req_job_id, work: req_work_units};

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_ARRIVE) begin
                  rsp_valid_in  = 1'b1;
                  rsp_run_id_in = '0;
                  rsp_left_in   = '0;
                  rsp_fin_in    = '0;
                  if (count_ff >= CNT_W'(QUEUE_DEPTH)) begin
                     rsp_status_in = STATUS_FULL;
                  end else if (req_work_units == '0) begin
                     rsp_status_in = STATUS_ZERO;
                  end else begin
                     rsp_status_in = STATUS_ACCEPT;
                     wr_en         = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end else if (!run_valid_ff && count_ff != '0) begin
                  // pick up the shortest ready job before running the tick
                  state_in   = S_SCAN;
                  preempt_in = 1'b0;
                  scan_in    = '0;
               end else begin
                  state_in = S_TICK;
               end
            end
         end

         S_SCAN: begin
            vld_in     = issue;
            cmp_idx_in = scan_ff;
            scan_in    = scan_ff + CNT_W'(issue);
            if (vld_ff && (cmp_idx_ff == '0 || rd_data_ff.work < best_ff.work)) begin
               best_in     = rd_data_ff;
               best_pos_in = cmp_idx_ff[IDX_W-1:0];
            end
            if (!issue && !vld_ff) begin
               if (preempt_ff && !(best_ff.work < run_work_ff)) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SHIFT;
                  scan_in  = CNT_W'(best_pos_ff) + CNT_W'(1);
               end
            end
         end

         S_SHIFT: begin
            // close up behind the taken entry: read one ahead, write one back
            vld_in     = issue;
            cmp_idx_in = scan_ff;
            scan_in    = scan_ff + CNT_W'(issue);
            if (vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = wr_pos[IDX_W-1:0];
               wr_data = rd_data_ff;
            end
            if (!issue && !vld_ff) begin
               run_valid_in = 1'b1;
               run_id_in    = best_ff.id;
               run_work_in  = best_ff.work;
               if (preempt_ff) begin
                  // preempted job goes to the back; count is unchanged
                  wr_en    = 1'b1;
                  wr_addr  = count_dec[IDX_W-1:0];
                  wr_data  = '{id: run_id_ff, work: run_work_ff};
                  state_in = S_IDLE;
               end else begin
                  count_in = count_dec;
                  state_in = S_TICK;
               end
            end
         end

         S_TICK: begin
            tick_in      = tick_next;
            rsp_valid_in = 1'b1;
            rsp_fin_in   = '0;
            state_in     = S_IDLE;
            if (!run_valid_ff) begin
               rsp_status_in = STATUS_IDLE;
               rsp_run_id_in = '0;
               rsp_left_in   = '0;
            end else begin
               rsp_run_id_in = run_id_ff;
               rsp_left_in   = left;
               run_work_in   = left;
               if (left == '0) begin
                  rsp_status_in = STATUS_DONE;
                  rsp_fin_in    = tick_next;
                  run_valid_in  = 1'b0;
                  run_id_in     = '0;
               end else begin
                  rsp_status_in = STATUS_RAN;
                  if (count_ff != '0) begin
                     state_in   = S_SCAN;
                     preempt_in = 1'b1;
                     scan_in    = '0;
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `SRTF_ASSERT(a_count_bound, count_ff <= CNT_W'(QUEUE_DEPTH), "ready count above depth")
   `SRTF_ASSERT(a_run_work, !run_valid_ff || run_work_ff != '0, "running job with no work")
   `SRTF_ASSERT_NEXT(a_tick_busy, start && !busy && req_cmd == CMD_TICK, busy, "tick not taken up")
   `SRTF_ASSERT(a_shift_pos, !(state_ff == S_SHIFT && vld_ff) || cmp_idx_ff != '0, "shift into position below zero")

endmodule
